/* sv/block_transfer_address_sequencer_top_assert.svh */
// Assertion macros used by the sequencer RTL.
`ifndef BLOCK_TRANSFER_ADDRESS_SEQUENCER_TOP_ASSERT_SVH
`define BLOCK_TRANSFER_ADDRESS_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BTAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BTAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/btas_pkg.sv */
// Shared types and constants for the block transfer address sequencer.
package btas_pkg;

    localparam int LIST_BITS          = 16;
    localparam int ADDR_W             = 32;
    localparam int REG_IDX_W          = 4;
    localparam int COUNT_W            = 5;
    localparam int REGISTER_COUNT_DEF = 16;
    localparam int WORD_BYTES         = 4;

    typedef logic [ADDR_W-1:0]    word_t;
    typedef logic [LIST_BITS-1:0] list_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // Addressing modes
    localparam logic [1:0] MODE_IA = 2'd0;
    localparam logic [1:0] MODE_IB = 2'd1;
    localparam logic [1:0] MODE_DA = 2'd2;
    localparam logic [1:0] MODE_DB = 2'd3;

    // Shared adder operations
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic  op;
        word_t a;
        word_t b;
    } alu_req_t;

endpackage

/* sv/btas_alu.sv */
// Shared 32-bit add/subtract unit used for writeback, start address and stepping.
module btas_alu (
    input  btas_pkg::alu_req_t req,
    output btas_pkg::word_t    y
);

    always_comb
    begin
        case (req.op)
            btas_pkg::ALU_ADD: y = req.a + req.b;
            btas_pkg::ALU_SUB: y = req.a - req.b;
            default:           y = req.a + req.b;
        endcase
    end

endmodule

/* sv/btas_seq.sv */
// Sequencer: captures one instruction and walks its register list one beat at a time.
`include "block_transfer_address_sequencer_top_assert.svh"

module btas_seq #(
    parameter int REGISTER_COUNT = btas_pkg::REGISTER_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                arm9_rules,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                action,
    input  logic [1:0]          address_mode,
    input  btas_pkg::list_t     register_list,
    input  btas_pkg::reg_idx_t  base_index,
    input  btas_pkg::word_t     base_value,
    output btas_pkg::alu_req_t  alu_req,
    input  btas_pkg::word_t     alu_y,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                transfer_valid,
    output btas_pkg::word_t     transfer_address,
    output btas_pkg::reg_idx_t  register_number,
    output logic                is_load,
    output logic                writeback_enable,
    output btas_pkg::word_t     writeback_value,
    output logic                last
);

    localparam int USABLE = (REGISTER_COUNT < btas_pkg::LIST_BITS) ?
                            REGISTER_COUNT : btas_pkg::LIST_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COUNT = 3'd1;
    localparam logic [2:0] S_WB    = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic               load_reg;
    logic [1:0]         mode_reg;
    btas_pkg::list_t    left_reg, left_next;
    btas_pkg::reg_idx_t base_idx_reg;
    btas_pkg::word_t    base_reg;
    btas_pkg::count_t   count_reg;
    logic               wben_reg;
    btas_pkg::word_t    wbval_reg;
    btas_pkg::word_t    addr_reg;

    logic               res_valid_reg;
    logic               res_tv_reg;
    btas_pkg::word_t    res_addr_reg;
    btas_pkg::reg_idx_t res_num_reg;
    logic               res_load_reg;
    logic               res_wben_reg;
    btas_pkg::word_t    res_wbval_reg;
    logic               res_last_reg;

    btas_pkg::list_t    list_mask;
    btas_pkg::count_t   popcount;
    btas_pkg::reg_idx_t low_idx;
    logic               wben_calc;
    logic               slot_free;
    logic               emit_load;
    logic               final_beat;

    always_comb
    begin
        for (int i = 0; i < btas_pkg::LIST_BITS; i++)
        begin
            list_mask[i] = (i < USABLE);
        end
    end

    always_comb
    begin
        popcount = '0;
        for (int i = 0; i < btas_pkg::LIST_BITS; i++)
        begin
            popcount = popcount + btas_pkg::count_t'(left_reg[i]);
        end
    end

    // Lowest listed register still to go
    always_comb
    begin
        low_idx = '0;
        for (int i = btas_pkg::LIST_BITS - 1; i >= 0; i--)
        begin
            if (left_reg[i])
            begin
                low_idx = btas_pkg::reg_idx_t'(i);
            end
        end
    end

    always_comb
    begin
        logic in_list;
        logic only;
        logic not_highest;
        in_list     = left_reg[base_idx_reg];
        only        = (left_reg == (btas_pkg::list_t'(1) << base_idx_reg));
        not_highest = ((left_reg >> base_idx_reg) != btas_pkg::list_t'(1));
        wben_calc   = !load_reg || !in_list || (arm9_rules && (only || not_highest));
    end

    // Operand selection for the shared adder
    always_comb
    begin
        alu_req.op = btas_pkg::ALU_ADD;
        alu_req.a  = addr_reg;
        alu_req.b  = btas_pkg::word_t'(btas_pkg::WORD_BYTES);
        case (state_reg)
            S_WB:
            begin
                alu_req.op = mode_reg[1] ? btas_pkg::ALU_SUB : btas_pkg::ALU_ADD;
                alu_req.a  = base_reg;
                alu_req.b  = btas_pkg::word_t'({count_reg, 2'b00});
            end
            S_START:
            begin
                alu_req.a = mode_reg[1] ? wbval_reg : base_reg;
                if (mode_reg inside {btas_pkg::MODE_IB, btas_pkg::MODE_DA})
                begin
                    alu_req.b = btas_pkg::word_t'(btas_pkg::WORD_BYTES);
                end
                else
                begin
                    alu_req.b = '0;
                end
            end
            default:
            begin
                alu_req.a = addr_reg;
            end
        endcase
    end

    assign item_ready = (state_reg == S_IDLE);
    assign slot_free  = !res_valid_reg || result_ready;
    assign emit_load  = (state_reg == S_EMIT) && slot_free;
    assign final_beat = (count_reg == '0) ||
                        ((left_reg & (left_reg - btas_pkg::list_t'(1))) == '0);

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = S_COUNT;
                    left_next  = register_list & list_mask;
                end
            end
            S_COUNT: state_next = S_WB;
            S_WB:    state_next = (count_reg == '0) ? S_EMIT : S_START;
            S_START: state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                begin
                    left_next = left_reg & (left_reg - btas_pkg::list_t'(1));
                    if (final_beat)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        if (state_reg == S_IDLE && item_valid)
        begin
            load_reg     <= action;
            mode_reg     <= address_mode;
            base_idx_reg <= base_index;
            base_reg     <= base_value;
        end
        if (state_reg == S_COUNT)
        begin
            count_reg <= popcount;
            wben_reg  <= wben_calc;
        end
        if (state_reg == S_WB)
        begin
            wbval_reg <= alu_y;
        end
        if (state_reg == S_START || emit_load)
        begin
            addr_reg <= alu_y;
        end
        if (emit_load)
        begin
            res_tv_reg    <= (count_reg != '0);
            res_addr_reg  <= (count_reg != '0) ? addr_reg : '0;
            res_num_reg   <= (count_reg != '0) ? low_idx : '0;
            res_load_reg  <= load_reg;
            res_wben_reg  <= final_beat ? ((count_reg == '0) || wben_reg) : 1'b0;
            res_wbval_reg <= final_beat ? wbval_reg : '0;
            res_last_reg  <= final_beat;
        end
    end

    assign result_valid     = res_valid_reg;
    assign transfer_valid   = res_tv_reg;
    assign transfer_address = res_addr_reg;
    assign register_number  = res_num_reg;
    assign is_load          = res_load_reg;
    assign writeback_enable = res_wben_reg;
    assign writeback_value  = res_wbval_reg;
    assign last             = res_last_reg;

    `BTAS_ASSERT_NOW(a_mid_no_wb, result_valid && !last,
        !writeback_enable && writeback_value == '0, "writeback on a non-final beat")
    `BTAS_ASSERT_NOW(a_empty_last, result_valid && !transfer_valid, last,
        "empty-list beat not marked last")
    `BTAS_ASSERT_NEXT(a_step_one, emit_load && count_reg != '0,
        $countones(left_reg) == $countones($past(left_reg)) - 1,
        "list did not drop exactly one register")
    `BTAS_ASSERT_NEXT(a_final_empty, emit_load && final_beat,
        left_reg == '0 && state_reg == S_IDLE, "registers left after the final beat")

endmodule

/* sv/block_transfer_address_sequencer_top.sv */
// Block transfer address sequencer: one load/store-multiple instruction in, one beat per register out.
//
// Usage:
//   Input channel (item_valid/item_ready) takes one instruction: action, address_mode,
//   register_list, base_index and base_value. Output channel (result_valid/result_ready)
//   gives one beat per listed register in ascending order with its word address,
//   register number and direction; the last beat carries writeback_enable and
//   writeback_value. An empty list gives a single beat with transfer_valid low.
//   cfg_write_enable/cfg_write_data write arm9_rules (base writeback rule for loads);
//   write it only while no instruction is in flight.
// Timing:
//   After acceptance the block steps through S_COUNT, S_WB, S_START and S_EMIT
//   (no S_START for an empty list), then registers the first beat in the output.
//   One beat per cycle follows while result_ready stays high. The single shared adder
//   computes the writeback value, the start address and each next address.
//   item_ready is high only while the block is idle; it rises once the last beat has
//   been loaded into the output register, even if that beat still waits.
// Reset: rst_n clears the sequencer, drops result_valid and sets arm9_rules to 1.
// Stall: while result_ready is low the current beat holds and stepping pauses.
module block_transfer_address_sequencer_top #(
    parameter int REGISTER_COUNT = btas_pkg::REGISTER_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_enable,
    input  logic                cfg_write_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                action,
    input  logic [1:0]          address_mode,
    input  btas_pkg::list_t     register_list,
    input  btas_pkg::reg_idx_t  base_index,
    input  btas_pkg::word_t     base_value,
    output logic                result_valid,
    input  logic                result_ready,
    output logic                transfer_valid,
    output btas_pkg::word_t     transfer_address,
    output btas_pkg::reg_idx_t  register_number,
    output logic                is_load,
    output logic                writeback_enable,
    output btas_pkg::word_t     writeback_value,
    output logic                last
);

    logic               arm9_rules_reg;
    btas_pkg::alu_req_t alu_req;
    btas_pkg::word_t    alu_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm9_rules_reg <= 1'b1;
        end
        else if (cfg_write_enable)
        begin
            arm9_rules_reg <= cfg_write_data;
        end
    end

    btas_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    btas_seq #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_seq (
        .clk              (clk),
        .rst_n            (rst_n),
        .arm9_rules       (arm9_rules_reg),
        .item_valid       (item_valid),
        .item_ready       (item_ready),
        .action           (action),
        .address_mode     (address_mode),
        .register_list    (register_list),
        .base_index       (base_index),
        .base_value       (base_value),
        .alu_req          (alu_req),
        .alu_y            (alu_y),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .transfer_valid   (transfer_valid),
        .transfer_address (transfer_address),
        .register_number  (register_number),
        .is_load          (is_load),
        .writeback_enable (writeback_enable),
        .writeback_value  (writeback_value),
        .last             (last)
    );

endmodule
